// ===== hw/rtl/vltv_pkg.sv =====
package vltv_pkg;

    // Longest length field, in bytes.
    localparam int unsigned MaxHeaderBytes = 5;

    localparam int unsigned CfgWidth = 32;
    localparam int unsigned HdrCntWidth = 3;

    localparam logic [CfgWidth-1:0] MaxPayloadReset = 32'd65535;
    localparam logic [CfgWidth-1:0] BufferCapReset = 32'd65536;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_MAX_PAYLOAD = 1'b0,
        CFG_BUFFER_CAP  = 1'b1
    } vltv_cfg_idx_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_TYPE   = 2'd1,
        PH_VALUE  = 2'd2,
        PH_ERROR  = 2'd3
    } vltv_phase_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_INVALID = 2'd1,
        ERR_SIZE    = 2'd2,
        ERR_BUFFER  = 2'd3
    } vltv_err_t;

    typedef enum logic [2:0] {
        ST_PENDING     = 3'd0,
        ST_TYPE        = 3'd1,
        ST_VALUE       = 3'd2,
        ST_INVALID     = 3'd3,
        ST_SIZE_OVF    = 3'd4,
        ST_BUFFER_OVF  = 3'd5,
        ST_UNUSED6     = 3'd6,
        ST_UNUSED7     = 3'd7
    } vltv_status_t;

    typedef enum logic [0:0] {
        OP_BYTE  = 1'b0,
        OP_CLEAR = 1'b1
    } vltv_op_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [7:0]          out_byte;
        logic [CfgWidth-1:0] value_len;
        logic                last;
    } vltv_result_t;

    // Number of bytes in the shortest LEB128 encoding of v.
    function automatic logic [HdrCntWidth-1:0] varint_bytes(input logic [CfgWidth-1:0] v);
        logic [HdrCntWidth-1:0] n;
        begin
            if (v < (32'd1 << 7))
            begin
                n = 3'd1;
            end
            else if (v < (32'd1 << 14))
            begin
                n = 3'd2;
            end
            else if (v < (32'd1 << 21))
            begin
                n = 3'd3;
            end
            else if (v < (32'd1 << 28))
            begin
                n = 3'd4;
            end
            else
            begin
                n = 3'd5;
            end
            return n;
        end
    endfunction

endpackage

// ===== hw/rtl/vltv_if.sv =====
interface vltv_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface vltv_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic [31:0] value_len;
    logic        last;

    modport source (output valid, output status, output out_byte, output value_len,
                    output last, input ready);
    modport sink (input valid, input status, input out_byte, input value_len,
                  input last, output ready);
endinterface

// ===== hw/rtl/vltv_cfg_regs.sv =====
module vltv_cfg_regs
    import vltv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [CfgWidth-1:0] cfg_data,
    output logic [CfgWidth-1:0] max_payload,
    output logic [CfgWidth-1:0] buffer_cap
);

    logic [CfgWidth-1:0] max_payload_reg;
    logic [CfgWidth-1:0] buffer_cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MaxPayloadReset;
            buffer_cap_reg  <= BufferCapReset;
        end
        else if (cfg_we)
        begin
            unique case (vltv_cfg_idx_t'(cfg_index))
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                CFG_BUFFER_CAP:  buffer_cap_reg  <= cfg_data;
            endcase
        end
    end

    assign max_payload = max_payload_reg;
    assign buffer_cap  = buffer_cap_reg;

endmodule

// ===== hw/rtl/vltv_parser.sv =====
module vltv_parser
    import vltv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                op,
    input  logic [7:0]          data_byte,
    input  logic [CfgWidth-1:0] max_payload,
    input  logic [CfgWidth-1:0] buffer_cap,
    output vltv_result_t        result
);

    vltv_phase_t            phase_reg, phase_next;
    logic [CfgWidth-1:0]    accum_reg, accum_next;
    logic [HdrCntWidth-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [CfgWidth-1:0]    left_reg, left_next;
    vltv_err_t              err_reg, err_next;

    logic [CfgWidth-1:0]    shifted;
    logic [CfgWidth-1:0]    accum_new;
    logic [HdrCntWidth-1:0] idx_inc;
    logic [CfgWidth-1:0]    left_dec;
    logic                   cap_full;
    logic                   top_bad;
    logic                   not_minimal;
    logic                   size_ovf;
    logic                   frame_ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            accum_reg   <= '0;
            hdr_cnt_reg <= '0;
            left_reg    <= '0;
            err_reg     <= ERR_NONE;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            accum_reg   <= accum_next;
            hdr_cnt_reg <= hdr_cnt_next;
            left_reg    <= left_next;
            err_reg     <= err_next;
        end
    end

    // Place a length byte's seven payload bits (four in the fifth) at their group.
    always_comb
    begin
        unique case (hdr_cnt_reg)
            3'd0:    shifted = {25'd0, data_byte[6:0]};
            3'd1:    shifted = {18'd0, data_byte[6:0], 7'd0};
            3'd2:    shifted = {11'd0, data_byte[6:0], 14'd0};
            3'd3:    shifted = {4'd0, data_byte[6:0], 21'd0};
            3'd4:    shifted = {data_byte[3:0], 28'd0};
            default: shifted = '0;
        endcase
    end

    assign accum_new   = accum_reg | shifted;
    assign idx_inc     = hdr_cnt_reg + 3'd1;
    assign left_dec    = left_reg - 32'd1;
    assign cap_full    = buffer_cap <= {29'd0, hdr_cnt_reg};
    assign top_bad     = (hdr_cnt_reg >= HdrCntWidth'(MaxHeaderBytes - 1))
                         && (data_byte[7:4] != 4'd0);
    assign not_minimal = (varint_bytes(accum_new) != idx_inc) || (accum_new == '0);
    assign size_ovf    = {1'b0, accum_new} > ({1'b0, max_payload} + 33'd1);
    assign frame_ovf   = ({1'b0, accum_new} + {30'd0, idx_inc}) > {1'b0, buffer_cap};

    always_comb
    begin
        phase_next   = phase_reg;
        accum_next   = accum_reg;
        hdr_cnt_next = hdr_cnt_reg;
        left_next    = left_reg;
        err_next     = err_reg;
        result       = '0;

        if (vltv_op_t'(op) == OP_CLEAR)
        begin
            phase_next   = PH_HEADER;
            accum_next   = '0;
            hdr_cnt_next = '0;
            left_next    = '0;
            err_next     = ERR_NONE;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    priority if (cap_full)
                    begin
                        phase_next    = PH_ERROR;
                        err_next      = ERR_BUFFER;
                        result.status = ST_BUFFER_OVF;
                    end
                    else if (top_bad)
                    begin
                        phase_next    = PH_ERROR;
                        err_next      = ERR_INVALID;
                        result.status = ST_INVALID;
                    end
                    else if (data_byte[7])
                    begin
                        accum_next   = accum_new;
                        hdr_cnt_next = idx_inc;
                    end
                    else if (not_minimal)
                    begin
                        accum_next    = accum_new;
                        phase_next    = PH_ERROR;
                        err_next      = ERR_INVALID;
                        result.status = ST_INVALID;
                    end
                    else if (size_ovf)
                    begin
                        accum_next    = accum_new;
                        phase_next    = PH_ERROR;
                        err_next      = ERR_SIZE;
                        result.status = ST_SIZE_OVF;
                    end
                    else if (frame_ovf)
                    begin
                        accum_next    = accum_new;
                        phase_next    = PH_ERROR;
                        err_next      = ERR_BUFFER;
                        result.status = ST_BUFFER_OVF;
                    end
                    else
                    begin
                        accum_next   = accum_new;
                        hdr_cnt_next = idx_inc;
                        left_next    = accum_new;
                        phase_next   = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    result.status   = ST_TYPE;
                    result.out_byte = data_byte;
                    if (left_dec == '0)
                    begin
                        phase_next   = PH_HEADER;
                        accum_next   = '0;
                        hdr_cnt_next = '0;
                        left_next    = '0;
                        err_next     = ERR_NONE;
                        result.last  = 1'b1;
                    end
                    else
                    begin
                        left_next        = left_dec;
                        phase_next       = PH_VALUE;
                        result.value_len = left_dec;
                    end
                end
                PH_VALUE:
                begin
                    result.status   = ST_VALUE;
                    result.out_byte = data_byte;
                    if (left_dec == '0)
                    begin
                        phase_next   = PH_HEADER;
                        accum_next   = '0;
                        hdr_cnt_next = '0;
                        left_next    = '0;
                        err_next     = ERR_NONE;
                        result.last  = 1'b1;
                    end
                    else
                    begin
                        left_next = left_dec;
                    end
                end
                PH_ERROR:
                begin
                    result.status = 3'd2 + {1'b0, err_reg};
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/varint_length_ltv_deframer_top.sv =====
// Byte-stream deframer for messages built as an unsigned LEB128 length
// (one to five bytes, counting the type byte and the value bytes), one type
// byte and the value bytes. Every item on in_ch is either a stream byte or a
// clear command, and each item yields exactly one item on out_ch: pending for
// a length byte or a clear, the type byte with its value size, or a value
// byte, with the last flag set on the final byte of a message. Framing
// errors stick and are reported on every later byte until a clear arrives.
// The cfg port writes the payload limit and the buffer capacity; the user
// must write it only while no item is in flight; the block does not enforce it.
// An accepted item sits in the input register; the parser then updates its
// state and loads the result register. Throughput is one item per cycle
// while out_ch keeps ready high, limited by the parser state update that
// each byte depends on.
// Reset empties both registers, returns the parser to the header phase and
// loads the default limits. When the receiver stalls, the result register
// holds its item, the input register still takes one more item, and in_ch
// then deasserts ready until out_ch moves again.
module varint_length_ltv_deframer_top
    import vltv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    vltv_in_if.sink             in_ch,
    vltv_out_if.source          out_ch,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [CfgWidth-1:0] cfg_data
);

    logic                in_vld_reg;
    logic                in_op_reg;
    logic [7:0]          in_byte_reg;
    logic                out_vld_reg;
    vltv_result_t        out_res_reg;
    vltv_result_t        result;
    logic                advance;
    logic [CfgWidth-1:0] max_payload;
    logic [CfgWidth-1:0] buffer_cap;

    // The parser advances whenever a held input can move into a free or
    // draining result register.
    assign advance     = in_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready = !in_vld_reg || advance;

    vltv_cfg_regs u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .max_payload (max_payload),
        .buffer_cap  (buffer_cap)
    );

    vltv_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .op          (in_op_reg),
        .data_byte   (in_byte_reg),
        .max_payload (max_payload),
        .buffer_cap  (buffer_cap),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_vld_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_op_reg   <= in_ch.op;
            in_byte_reg <= in_ch.data_byte;
        end
        if (advance)
        begin
            out_res_reg <= result;
        end
    end

    assign out_ch.valid     = out_vld_reg;
    assign out_ch.status    = out_res_reg.status;
    assign out_ch.out_byte  = out_res_reg.out_byte;
    assign out_ch.value_len = out_res_reg.value_len;
    assign out_ch.last      = out_res_reg.last;

endmodule

// ===== dv/tb_varint_length_ltv_deframer_top.sv =====
module tb_varint_length_ltv_deframer_top;
    import vltv_pkg::*;

    // Quiet time after the last owed result has come out, before a register
    // write and at the end of the run.
    localparam int unsigned DrainCycles = 6;
    // A generous bound: every item waiting out the slowest receiver pattern,
    // every sender gap and both long hold-offs still ends far below this.
    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned LongHoldCycles = 60;
    localparam int unsigned ItemsPerPhase = 180;
    localparam int PhaseCount = 9;
    localparam int DirectedCount = 25;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [CfgWidth-1:0] cfg_data;

    vltv_in_if in_ch ();
    vltv_out_if out_ch ();

    varint_length_ltv_deframer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Parser state as this bench expects it to be, advanced once per accepted
    // item, together with its own copy of the two limit registers.
    vltv_phase_t pr_phase;
    logic [31:0] pr_length;
    logic [2:0] pr_hdr_count;
    logic [31:0] pr_remaining;
    vltv_err_t pr_error;
    logic [31:0] pr_max_payload;
    logic [31:0] pr_buffer_cap;

    // Results that accepted items still owe, oldest first.
    vltv_result_t parse_results_due[$];

    int unsigned error_count = 0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;

    // Sender burst shaping and receiver hold-off bookkeeping.
    bit sender_bursty = 1'b1;
    int unsigned burst_left = 0;
    int unsigned hold_requested = 0;
    int unsigned hold_served = 0;

    // Directed stimulus. Rows whose result is obvious carry it typed in;
    // the others are checked against the prediction.
    typedef struct {
        vltv_op_t     op;
        logic [7:0]   data_byte;
        bit           typed;
        vltv_status_t status;
        logic [7:0]   out_byte;
        logic [31:0]  value_len;
        logic         last;
    } directed_row_t;

    directed_row_t directed_rows [DirectedCount] = '{
        // A one-byte length of one: type byte only, value size zero, last set.
        '{OP_BYTE,  8'h01, 1'b1, ST_PENDING,    8'h00, 32'd0, 1'b0},
        '{OP_BYTE,  8'hFF, 1'b1, ST_TYPE,       8'hFF, 32'd0, 1'b1},
        // A length of three: type byte with two value bytes behind it.
        '{OP_BYTE,  8'h03, 1'b0, ST_PENDING,    8'h00, 32'd0, 1'b0},
        '{OP_BYTE,  8'h00, 1'b1, ST_TYPE,       8'h00, 32'd2, 1'b0},
        '{OP_BYTE,  8'hA5, 1'b0, ST_PENDING,    8'h00, 32'd0, 1'b0},
        '{OP_BYTE,  8'h5A, 1'b1, ST_VALUE,      8'h5A, 32'd0, 1'b1},
        // A zero length is invalid, and the error then sticks.
        '{OP_BYTE,  8'h00, 1'b1, ST_INVALID,    8'h00, 32'd0, 1'b0},
        '{OP_BYTE,  8'h77, 1'b1, ST_INVALID,    8'h00, 32'd0, 1'b0},
        '{OP_CLEAR, 8'hFF, 1'b1, ST_PENDING,    8'h00, 32'd0, 1'b0},
        // A length of one spread over two bytes is not minimal.
        '{OP_BYTE,  8'h81, 1'b0, ST_PENDING,    8'h00, 32'd0, 1'b0},
        '{OP_BYTE,  8'h00, 1'b1, ST_INVALID,    8'h00, 32'd0, 1'b0},
        '{OP_CLEAR, 8'h00, 1'b1, ST_PENDING,    8'h00, 32'd0, 1'b0},
        // The fifth length byte may only use its low four bits.
        '{OP_BYTE,  8'h80, 1'b0, ST_PENDING,    8'h00, 32'd0, 1'b0},
        '{OP_BYTE,  8'h80, 1'b0, ST_PENDING,    8'h00, 32'd0, 1'b0},
        '{OP_BYTE,  8'h80, 1'b0, ST_PENDING,    8'h00, 32'd0, 1'b0},
        '{OP_BYTE,  8'h80, 1'b0, ST_PENDING,    8'h00, 32'd0, 1'b0},
        '{OP_BYTE,  8'h10, 1'b1, ST_INVALID,    8'h00, 32'd0, 1'b0},
        '{OP_CLEAR, 8'h5A, 1'b1, ST_PENDING,    8'h00, 32'd0, 1'b0},
        // A length of 65537 is one past the default payload limit.
        '{OP_BYTE,  8'h81, 1'b0, ST_PENDING,    8'h00, 32'd0, 1'b0},
        '{OP_BYTE,  8'h80, 1'b0, ST_PENDING,    8'h00, 32'd0, 1'b0},
        '{OP_BYTE,  8'h04, 1'b1, ST_SIZE_OVF,   8'h00, 32'd0, 1'b0},
        '{OP_CLEAR, 8'hA5, 1'b1, ST_PENDING,    8'h00, 32'd0, 1'b0},
        // A length of 65534 passes the payload limit, but with three header
        // bytes the frame is one byte larger than the default buffer.
        '{OP_BYTE,  8'hFE, 1'b0, ST_PENDING,    8'h00, 32'd0, 1'b0},
        '{OP_BYTE,  8'hFF, 1'b0, ST_PENDING,    8'h00, 32'd0, 1'b0},
        '{OP_BYTE,  8'h03, 1'b1, ST_BUFFER_OVF, 8'h00, 32'd0, 1'b0}
    };

    function automatic void restart_parser();
        pr_phase = PH_HEADER;
        pr_length = '0;
        pr_hdr_count = '0;
        pr_remaining = '0;
        pr_error = ERR_NONE;
    endfunction

    function automatic vltv_status_t error_status(input vltv_err_t err);
        case (err)
            ERR_SIZE:   return ST_SIZE_OVF;
            ERR_BUFFER: return ST_BUFFER_OVF;
            default:    return ST_INVALID;
        endcase
    endfunction

    function automatic vltv_result_t latch_error(input vltv_err_t err);
        vltv_result_t r;
        r = '0;
        pr_phase = PH_ERROR;
        pr_error = err;
        r.status = error_status(err);
        return r;
    endfunction

    // Works out the result of one accepted item and moves the expected
    // parser state on.
    function automatic vltv_result_t parse_stream_byte(input vltv_op_t op,
                                                       input logic [7:0] b);
        vltv_result_t r;
        int unsigned idx;
        int unsigned shortest;
        int unsigned k;
        logic [31:0] still_due;
        r = '0;
        if (op == OP_CLEAR)
        begin
            restart_parser();
            return r;
        end
        case (pr_phase)
            PH_HEADER:
            begin
                idx = 32'(pr_hdr_count);
                // The arriving header byte must itself fit in the buffer.
                if (idx + 1 > pr_buffer_cap)
                begin
                    return latch_error(ERR_BUFFER);
                end
                // The fifth group holds only four bits of a 32-bit length.
                if (idx >= MaxHeaderBytes - 1 && b[7:4] != 4'h0)
                begin
                    return latch_error(ERR_INVALID);
                end
                pr_length = pr_length | (32'(b[6:0]) << (7 * idx));
                if (b[7])
                begin
                    pr_hdr_count = 3'(idx + 1);
                    return r;
                end
                shortest = 1;
                for (k = 1; k < MaxHeaderBytes; k++)
                begin
                    if ((pr_length >> (7 * k)) != 0)
                    begin
                        shortest = k + 1;
                    end
                end
                if (shortest != idx + 1 || pr_length == 0)
                begin
                    return latch_error(ERR_INVALID);
                end
                if (64'(pr_length) > 64'(pr_max_payload) + 64'd1)
                begin
                    return latch_error(ERR_SIZE);
                end
                if (64'(idx) + 64'd1 + 64'(pr_length) > 64'(pr_buffer_cap))
                begin
                    return latch_error(ERR_BUFFER);
                end
                pr_hdr_count = 3'(idx + 1);
                pr_remaining = pr_length;
                pr_phase = PH_TYPE;
                return r;
            end
            PH_TYPE:
            begin
                still_due = pr_remaining - 32'd1;
                r.status = ST_TYPE;
                r.out_byte = b;
                if (still_due == 0)
                begin
                    restart_parser();
                    r.last = 1'b1;
                end
                else
                begin
                    pr_remaining = still_due;
                    pr_phase = PH_VALUE;
                    r.value_len = still_due;
                end
                return r;
            end
            PH_VALUE:
            begin
                pr_remaining = pr_remaining - 32'd1;
                r.status = ST_VALUE;
                r.out_byte = b;
                if (pr_remaining == 0)
                begin
                    restart_parser();
                    r.last = 1'b1;
                end
                return r;
            end
            default:
            begin
                // Stream bytes are dropped while an error is latched.
                r.status = error_status(pr_error);
                return r;
            end
        endcase
    endfunction

    // Offers one item and waits for it to be taken. The expectation is
    // recorded at the accepting edge; in bursty mode a gap may follow.
    task automatic send_item(input vltv_op_t op, input logic [7:0] data,
                             input bit has_typed = 1'b0,
                             input vltv_result_t typed = '0);
        vltv_result_t predicted;
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.data_byte <= data;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        predicted = parse_stream_byte(op, data);
        parse_results_due.push_back(has_typed ? typed : predicted);
        items_sent++;
        if (sender_bursty)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // Sends a LEB128 length, optionally padded with redundant zero groups
    // so that the encoding is longer than it needs to be.
    task automatic send_length(input logic [31:0] len, input int unsigned pad);
        logic [31:0] rest;
        logic [7:0] group;
        int unsigned k;
        rest = len;
        do
        begin
            group = {1'b0, rest[6:0]};
            rest = rest >> 7;
            if (rest != 0 || pad > 0)
            begin
                group[7] = 1'b1;
            end
            send_item(OP_BYTE, group);
        end
        while (rest != 0);
        for (k = pad; k > 0; k--)
        begin
            send_item(OP_BYTE, (k > 1) ? 8'h80 : 8'h00);
        end
    endtask

    // Type byte followed by the given number of value bytes, all random.
    task automatic send_body(input int unsigned value_count);
        send_item(OP_BYTE, 8'($urandom));
        repeat (value_count) send_item(OP_BYTE, 8'($urandom));
    endtask

    // One random message. Most are well formed with random content; the
    // rest are cut short, badly encoded, oversized or plain noise.
    task automatic send_random_message();
        int unsigned pick;
        int unsigned body_len;
        int unsigned n;
        int unsigned k;
        logic [31:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 62)
        begin
            n = $urandom_range(0, 99);
            if (n < 70)
            begin
                body_len = $urandom_range(0, 8);
            end
            else if (n < 96)
            begin
                body_len = $urandom_range(9, 40);
            end
            else
            begin
                body_len = $urandom_range(100, 300);
            end
            send_length(body_len + 1, 0);
            if (pick < 54 || body_len == 0)
            begin
                send_body(body_len);
            end
            else
            begin
                // Broken off part way through the value; cleared below.
                send_body($urandom_range(0, body_len - 1));
            end
        end
        else if (pick < 68)
        begin
            send_length($urandom_range(1, 200), $urandom_range(1, 3));
        end
        else if (pick < 72)
        begin
            send_length(32'd0, $urandom_range(0, 1));
        end
        else if (pick < 78)
        begin
            // Full five-byte length; the last group is mostly legal.
            for (k = 0; k < 4; k++)
            begin
                send_item(OP_BYTE, 8'h80 | 8'($urandom_range(0, 127)));
            end
            send_item(OP_BYTE, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, 15)));
            if (pr_phase == PH_TYPE)
            begin
                send_body($urandom_range(0, 4));
            end
        end
        else if (pick < 86)
        begin
            // Lengths of any size, minimally encoded; only a few bytes of
            // a huge body are sent before the frame is abandoned.
            len = $urandom >> $urandom_range(0, 31);
            if (len == 0)
            begin
                len = 32'd1;
            end
            send_length(len, 0);
            k = (len > 32'd7) ? 6 : 32'(len - 32'd1);
            send_body(k);
        end
        else if (pick < 94)
        begin
            n = $urandom_range(1, 4);
            repeat (n) send_item(($urandom_range(0, 7) == 0) ? OP_CLEAR : OP_BYTE,
                                 8'($urandom));
        end
        else
        begin
            send_item(OP_CLEAR, 8'($urandom));
        end
        // Leave no error latched and no broken frame behind, after up to two
        // bytes that the block has to drop or absorb.
        if (pr_phase == PH_ERROR || (pick >= 54 && pr_phase != PH_HEADER))
        begin
            repeat ($urandom_range(0, 2)) send_item(OP_BYTE, 8'($urandom));
            send_item(OP_CLEAR, 8'($urandom));
        end
    endtask

    // Holds the sender off until every owed result has come out.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (parse_results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Writes both limit registers on consecutive edges.
    task automatic write_limits(input logic [31:0] max_payload,
                                input logic [31:0] capacity);
        cfg_we <= 1'b1;
        cfg_index <= CFG_MAX_PAYLOAD;
        cfg_data <= max_payload;
        @(posedge clk);
        cfg_index <= CFG_BUFFER_CAP;
        cfg_data <= capacity;
        @(posedge clk);
        cfg_we <= 1'b0;
        pr_max_payload = max_payload;
        pr_buffer_cap = capacity;
    endtask

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            error_count++;
        end
    endfunction

    // Result checker: every item taken from out_ch is matched against the
    // oldest owed result.
    always @(posedge clk)
    begin : result_check
        vltv_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (parse_results_due.size() == 0)
            begin
                $error("result item with none owed: status 0x%0h", out_ch.status);
                error_count++;
            end
            else
            begin
                want = parse_results_due.pop_front();
                check_field("status", 32'(want.status), 32'(out_ch.status));
                check_field("out_byte", 32'(want.out_byte), 32'(out_ch.out_byte));
                check_field("value_len", want.value_len, out_ch.value_len);
                check_field("last", 32'(want.last), 32'(out_ch.last));
            end
        end
    end

    // Receiver. Its stall pattern is redrawn at random among always
    // ready, coin flips, mostly stalled and a fixed one-in-five stall. When
    // the stimulus asks for it, ready stays low for a long stretch so the
    // block fills up and pushes back on the sender.
    initial
    begin : receiver
        int unsigned stall_tick;
        int unsigned stall_mode;
        stall_tick = 0;
        stall_mode = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            stall_tick++;
            if (hold_served != hold_requested)
            begin
                out_ch.ready <= 1'b0;
                repeat (LongHoldCycles - 1) @(posedge clk);
                hold_served++;
            end
            else
            begin
                if (stall_tick % 64 == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                end
                case (stall_mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 1) == 1);
                    2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= (stall_tick % 5 != 0);
                endcase
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("tb_varint_length_ltv_deframer_top: done, errors");
            $finish;
        end
    end

    // Main sequence: reset, the directed table under the default limits,
    // then phases of random messages, each under its own pair of limits.
    // The limits are only rewritten once the block has gone quiet.
    initial
    begin : stimulus
        logic [31:0] phase_max_payload [PhaseCount];
        logic [31:0] phase_buffer_cap [PhaseCount];
        vltv_result_t typed_result;
        int unsigned phase_goal;
        int row;
        int ph;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_MAX_PAYLOAD;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.op <= OP_BYTE;
        in_ch.data_byte <= 8'h00;
        pr_max_payload = MaxPayloadReset;
        pr_buffer_cap = BufferCapReset;
        restart_parser();

        // Phase 0 keeps the reset limits. The others cover the widest
        // limits, a one-byte buffer where every frame overflows, the
        // smallest buffer that still fits a frame, and a few in between.
        phase_max_payload[1] = 32'hFFFF_FFFE;
        phase_buffer_cap[1] = 32'hFFFF_FFFF;
        phase_max_payload[2] = 32'd0;
        phase_buffer_cap[2] = 32'd1;
        phase_max_payload[3] = 32'd0;
        phase_buffer_cap[3] = 32'd2;
        phase_max_payload[4] = 32'd3;
        phase_buffer_cap[4] = 32'd8;
        phase_max_payload[5] = $urandom_range(4, 40);
        phase_buffer_cap[5] = $urandom_range(8, 64);
        phase_max_payload[6] = 32'd20;
        phase_buffer_cap[6] = 32'hFFFF_FFFF;
        phase_max_payload[7] = 32'hFFFF_FFFE;
        phase_buffer_cap[7] = 32'd30;
        phase_max_payload[8] = $urandom_range(100, 1000);
        phase_buffer_cap[8] = $urandom | 32'd1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DirectedCount; row++)
        begin
            typed_result.status = directed_rows[row].status;
            typed_result.out_byte = directed_rows[row].out_byte;
            typed_result.value_len = directed_rows[row].value_len;
            typed_result.last = directed_rows[row].last;
            send_item(directed_rows[row].op, directed_rows[row].data_byte,
                      directed_rows[row].typed, typed_result);
        end

        for (ph = 0; ph < PhaseCount; ph++)
        begin
            wait_drained();
            if (ph != 0)
            begin
                write_limits(phase_max_payload[ph], phase_buffer_cap[ph]);
            end
            // Every third phase the sender offers items back to back.
            sender_bursty = (ph % 3 != 2);
            burst_left = 0;
            if (ph == 1 || ph == 6)
            begin
                hold_requested++;
            end
            phase_goal = items_sent + ItemsPerPhase;
            send_item(OP_CLEAR, 8'($urandom));
            while (items_sent < phase_goal)
            begin
                send_random_message();
            end
        end

        wait_drained();
        if (error_count == 0)
        begin
            $display("tb_varint_length_ltv_deframer_top: done, clean");
        end
        else
        begin
            $display("tb_varint_length_ltv_deframer_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/vltv_pkg.sv
hw/rtl/vltv_if.sv
hw/rtl/vltv_cfg_regs.sv
hw/rtl/vltv_parser.sv
hw/rtl/varint_length_ltv_deframer_top.sv
dv/tb_varint_length_ltv_deframer_top.sv
